// ----- rtl/pfc_pkg.sv -----
package pfc_pkg;

  localparam logic [4:0] LetterI = 5'd8;
  localparam logic [4:0] LetterJ = 5'd9;
  localparam logic [4:0] LetterX = 5'd23;
  localparam logic [4:0] NonLetter = 5'd31;
  localparam logic [4:0] NumLetters = 5'd26;
  localparam int unsigned SideLen = 5;
  localparam int unsigned NumCells = SideLen * SideLen;
  localparam logic [6:0] AsciiA = 7'd65;

  localparam int unsigned CfgDataW = 45;
  localparam int unsigned PartAW = 45;
  localparam int unsigned PartBW = 40;
  localparam int unsigned PartCW = 40;

  typedef enum logic [1:0] {
    CfgMode  = 2'd0,
    CfgPartA = 2'd1,
    CfgPartB = 2'd2,
    CfgPartC = 2'd3
  } cfg_idx_e;

  typedef logic [NumCells-1:0][4:0] square_t;

  typedef struct packed {
    logic       any;
    logic       two;
    logic       fin;
    logic [4:0] a0;
    logic [4:0] b0;
    logic [4:0] a1;
    logic [4:0] b1;
  } job_t;

  function automatic logic [4:0] letter_of(logic [7:0] c);
    logic [4:0] v;
    v = NonLetter;
    if (c >= 8'd65 && c <= 8'd90) begin
      v = 5'(c - 8'd65);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      v = 5'(c - 8'd97);
    end
    if (v == LetterJ) begin
      v = LetterI;
    end
    return v;
  endfunction

  // highest matching cell wins; absent or non-letter maps to cell 0
  function automatic logic [4:0] locate(logic [4:0] idx, square_t sq);
    logic [4:0] at;
    at = '0;
    if (idx < NumLetters) begin
      for (int k = 0; k < NumCells; k++) begin
        if (sq[k] == idx) begin
          at = 5'(k);
        end
      end
    end
    return at;
  endfunction

  function automatic logic [2:0] row_of(logic [4:0] pos);
    logic [2:0] r;
    if (pos >= 5'd20) r = 3'd4;
    else if (pos >= 5'd15) r = 3'd3;
    else if (pos >= 5'd10) r = 3'd2;
    else if (pos >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic logic [4:0] times5(logic [2:0] r);
    return {r, 2'b00} + {2'b00, r};
  endfunction

  function automatic logic [2:0] step5(logic [2:0] v, logic [2:0] sh);
    logic [3:0] s;
    s = {1'b0, v} + {1'b0, sh};
    if (s >= 4'd5) begin
      s = s - 4'd5;
    end
    return s[2:0];
  endfunction

endpackage

// ----- rtl/playfair_cipher_stream.sv -----
// A byte's first letter passes the job register and then the output register.
// Throughput: one letter per cycle unless out_ready_i stalls, set by the single
// output register; a byte yields 0, 2 or 4 letters; next byte enters with its last.
// Reset (rst_ni low, async): no letter held, output empty, mode encrypt,
// key square all zero.
module playfair_cipher_stream (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [pfc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   char_code_i,
  input  logic                         final_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [6:0]                   letter_o,
  output logic                         run_last_o,
  output logic                         message_last_o
);

  logic                       mode_q;
  logic [pfc_pkg::PartAW-1:0] part_a_q;
  logic [pfc_pkg::PartBW-1:0] part_b_q;
  logic [pfc_pkg::PartCW-1:0] part_c_q;
  pfc_pkg::square_t           square;

  pfc_pkg::job_t job_new, job_q;
  logic          job_valid_q;
  logic [1:0]    cnt_q;
  logic          accept, out_free, job_adv, job_last;
  logic [4:0]    cur_a, cur_b;
  logic [6:0]    letter_d;
  logic          out_valid_q, run_last_q, message_last_q;
  logic [6:0]    letter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      part_a_q <= '0;
      part_b_q <= '0;
      part_c_q <= '0;
    end else if (cfg_we_i) begin
      unique case (pfc_pkg::cfg_idx_e'(cfg_idx_i))
        pfc_pkg::CfgMode:  mode_q   <= cfg_data_i[0];
        pfc_pkg::CfgPartA: part_a_q <= cfg_data_i[pfc_pkg::PartAW-1:0];
        pfc_pkg::CfgPartB: part_b_q <= cfg_data_i[pfc_pkg::PartBW-1:0];
        pfc_pkg::CfgPartC: part_c_q <= cfg_data_i[pfc_pkg::PartCW-1:0];
        default: ;
      endcase
    end
  end

  assign square = {part_c_q, part_b_q, part_a_q};

  assign out_free   = !out_valid_q || out_ready_i;
  assign job_adv    = job_valid_q && out_free;
  assign job_last   = cnt_q[0] && (cnt_q[1] == job_q.two);
  assign in_ready_o = !job_valid_q || (job_adv && job_last);
  assign accept     = in_valid_i && in_ready_o;

  pfc_pairing u_pairing (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .mode_i       (mode_q),
    .char_code_i  (char_code_i),
    .final_byte_i (final_byte_i),
    .job_o        (job_new)
  );

  assign cur_a = cnt_q[1] ? job_q.a1 : job_q.a0;
  assign cur_b = cnt_q[1] ? job_q.b1 : job_q.b0;

  pfc_cipher u_cipher (
    .mode_i   (mode_q),
    .square_i (square),
    .a_i      (cur_a),
    .b_i      (cur_b),
    .second_i (cnt_q[0]),
    .letter_o (letter_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else if (accept && job_new.any) begin
      job_valid_q <= 1'b1;
      cnt_q       <= '0;
    end else if (job_adv) begin
      if (job_last) begin
        job_valid_q <= 1'b0;
      end
      cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && job_new.any) begin
      job_q <= job_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (job_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_adv) begin
      letter_q       <= letter_d;
      run_last_q     <= job_last;
      message_last_q <= job_last && job_q.fin;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign letter_o       = letter_q;
  assign run_last_o     = run_last_q;
  assign message_last_o = message_last_q;

endmodule

// ----- rtl/pfc_pairing.sv -----
module pfc_pairing (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          mode_i,
  input  logic [7:0]    char_code_i,
  input  logic          final_byte_i,
  output pfc_pkg::job_t job_o
);

  logic [4:0] held_q, held_d;
  logic       held_valid_q, held_valid_d;

  always_comb begin
    logic [4:0] v;
    logic       first;
    logic       flush;
    logic [4:0] fa, fb, pa, pb;
    v     = pfc_pkg::letter_of(char_code_i);
    first = 1'b0;
    flush = 1'b0;
    fa    = held_q;
    fb    = v;
    pb    = pfc_pkg::LetterX;
    held_d       = held_q;
    held_valid_d = held_valid_q;

    if (!mode_i) begin
      if (v != pfc_pkg::NonLetter) begin
        if (!held_valid_q) begin
          held_d       = v;
          held_valid_d = 1'b1;
        end else if (held_q == v) begin
          first = 1'b1;
          fb    = pfc_pkg::LetterX;
        end else begin
          first        = 1'b1;
          held_valid_d = 1'b0;
        end
      end
      pb = pfc_pkg::LetterX;
    end else begin
      if (!held_valid_q) begin
        held_d       = v;
        held_valid_d = 1'b1;
      end else begin
        first        = 1'b1;
        held_valid_d = 1'b0;
      end
      pb = pfc_pkg::NonLetter;
    end

    flush = final_byte_i && held_valid_d;
    pa    = held_d;

    if (final_byte_i) begin
      held_d       = '0;
      held_valid_d = 1'b0;
    end

    job_o.any = first || flush;
    job_o.two = first && flush;
    job_o.fin = final_byte_i;
    job_o.a0  = first ? fa : pa;
    job_o.b0  = first ? fb : pb;
    job_o.a1  = pa;
    job_o.b1  = pb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      held_valid_q <= 1'b0;
    end else if (accept_i) begin
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
    end
  end

endmodule

// ----- rtl/pfc_cipher.sv -----
module pfc_cipher (
  input  logic             mode_i,
  input  pfc_pkg::square_t square_i,
  input  logic [4:0]       a_i,
  input  logic [4:0]       b_i,
  input  logic             second_i,
  output logic [6:0]       letter_o
);

  logic [4:0] pa, pb, x, y, sel;
  logic [2:0] ra, ca, rb, cb, sh;

  always_comb begin
    pa = pfc_pkg::locate(a_i, square_i);
    pb = pfc_pkg::locate(b_i, square_i);
    ra = pfc_pkg::row_of(pa);
    rb = pfc_pkg::row_of(pb);
    ca = 3'(pa - pfc_pkg::times5(ra));
    cb = 3'(pb - pfc_pkg::times5(rb));
    sh = mode_i ? 3'd4 : 3'd1;
    if (ra == rb) begin
      x = pfc_pkg::times5(ra) + {2'b00, pfc_pkg::step5(ca, sh)};
      y = pfc_pkg::times5(rb) + {2'b00, pfc_pkg::step5(cb, sh)};
    end else if (ca == cb) begin
      x = pfc_pkg::times5(pfc_pkg::step5(ra, sh)) + {2'b00, ca};
      y = pfc_pkg::times5(pfc_pkg::step5(rb, sh)) + {2'b00, cb};
    end else begin
      x = pfc_pkg::times5(ra) + {2'b00, cb};
      y = pfc_pkg::times5(rb) + {2'b00, ca};
    end
    sel      = second_i ? y : x;
    letter_o = pfc_pkg::AsciiA + {2'b00, square_i[sel]};
  end

endmodule

// ----- rtl/pfc_checker.sv -----
module pfc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [6:0] letter_o,
  input logic       run_last_o,
  input logic       message_last_o
);

  a_msg_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_last_o |-> run_last_o)
    else $error("message_last without run_last");

  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (letter_o >= 7'd65 && letter_o <= 7'd96))
    else $error("letter out of range");

  a_busy_means_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> out_valid_o)
    else $error("input stalled with no letter following");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(letter_o))
    else $error("stalled output transfer changed");

endmodule

bind playfair_cipher_stream pfc_checker u_pfc_checker (.*);
